>>> hdl/irm_pkg.sv
// Shared types and constants for the interval range map.
// No dependencies; imported by the top level and the RAM.
package irm_pkg;

    // Default sizing
    localparam int DEF_MAX_BOUNDS = 32;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 8;

    // Result status codes
    localparam int STATUS_W = 2;
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // Input word kinds (carried in tuser)
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_ASSIGN = 1'b1;

endpackage

>>> hdl/irm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on irm_pkg for nothing beyond house conventions.
module irm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import irm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/interval_range_map_top.sv
// Interval range map: sorted boundary table held in two ping-pong RAMs.
// Depends on irm_pkg and irm_ram.
//
// A lookup scans the whole table with one RAM read turn per boundary; an assign
// does the same, plus the two new edges.
// Throughput: one word at a time, set by the table scan through the RAM read port.
// An assign rewrites the table into the idle bank and swaps banks on success.
// Reset (synchronous, active low) empties the table, clears the default value
// and drops any pending result; RAM contents are not cleared.
module interval_range_map_top #(
    parameter int MAX_BOUNDS = irm_pkg::DEF_MAX_BOUNDS,
    parameter int KEY_BITS   = irm_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = irm_pkg::DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration: default_value
    input  logic                  i_cfg_wen,
    input  logic [VALUE_BITS-1:0] i_cfg_wdata,
    // input stream
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tdata: key_begin, key_end, new_value (low bits up), zero padded
    input  logic [((2*KEY_BITS+VALUE_BITS+7)/8)*8-1:0] i_s_tdata,
    // tuser: action
    input  logic i_s_tuser,
    // output stream
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // tdata: read_value, status (low bits up), zero padded
    output logic [((VALUE_BITS+irm_pkg::STATUS_W+7)/8)*8-1:0] o_m_tdata
);
    import irm_pkg::*;

    localparam int AW    = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1;
    localparam int CW    = $clog2(MAX_BOUNDS + 1);
    localparam int EW    = KEY_BITS + VALUE_BITS;
    localparam int OUT_W = ((VALUE_BITS + STATUS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_DONE} t_state;
    typedef enum logic [1:0] {PH_BEGIN, PH_END, PH_TAIL} t_phase;

    t_state r_state;
    t_phase r_phase;

    logic                       r_act;
    logic signed [KEY_BITS-1:0] r_kb, r_ke;
    logic [VALUE_BITS-1:0]      r_val, r_default, r_res, r_endv, r_prev;
    logic [CW-1:0]              r_idx, r_count, r_m;
    logic                       r_ovf, r_bank;
    t_status                    r_stat;
    logic                       r_oval;
    logic [OUT_W-1:0]           r_odata;

    logic [EW-1:0]              q0, q1, rd_data;
    logic signed [KEY_BITS-1:0] cur_key;
    logic [VALUE_BITS-1:0]      cur_val;
    logic                       at_end;
    logic                       out_load;

    // Emission into the new table
    logic                       e_do, e_adv, e_new, wr_en;
    logic signed [KEY_BITS-1:0] e_key;
    logic [VALUE_BITS-1:0]      e_v;
    t_phase                     e_phase;

    assign rd_data = r_bank ? q1 : q0;
    assign cur_key = $signed(rd_data[KEY_BITS-1:0]);
    assign cur_val = rd_data[EW-1:KEY_BITS];
    assign at_end  = (r_idx == r_count);

    // Load the output register once the result is ready and the slot is free
    assign out_load = (r_state == S_DONE) && (!r_oval || i_m_tready);

    // Decide one emission per evaluate cycle of an assign
    always_comb begin
        e_do    = 1'b0;
        e_adv   = 1'b0;
        e_key   = cur_key;
        e_v     = cur_val;
        e_phase = r_phase;
        case (r_phase)
            PH_BEGIN: begin
                if (!at_end && cur_key < r_kb) begin
                    e_do  = 1'b1;
                    e_adv = 1'b1;
                end else begin
                    e_do    = 1'b1;
                    e_key   = r_kb;
                    e_v     = r_val;
                    e_phase = PH_END;
                end
            end
            PH_END: begin
                if (!at_end && cur_key <= r_ke) begin
                    e_adv = 1'b1;
                end else begin
                    e_do    = 1'b1;
                    e_key   = r_ke;
                    e_v     = r_endv;
                    e_phase = PH_TAIL;
                end
            end
            default: begin
                if (!at_end) begin
                    e_do  = 1'b1;
                    e_adv = 1'b1;
                end
            end
        endcase
    end

    assign e_new = (r_state == S_EV) && r_act && e_do && (e_v != r_prev);
    assign wr_en = e_new && !r_ovf && (r_m != CW'(MAX_BOUNDS));

    // Two banks: read the live one, build into the other
    irm_ram #(.WIDTH(EW), .DEPTH(MAX_BOUNDS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_bank),
        .i_waddr (r_m[AW-1:0]),
        .i_wdata ({e_v, e_key}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (q0)
    );

    irm_ram #(.WIDTH(EW), .DEPTH(MAX_BOUNDS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !r_bank),
        .i_waddr (r_m[AW-1:0]),
        .i_wdata ({e_v, e_key}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (q1)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_odata;

    // Sequencer, table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_BEGIN;
            r_default <= '0;
            r_count   <= '0;
            r_bank    <= 1'b0;
            r_oval    <= 1'b0;
            r_idx     <= '0;
            r_m       <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_default <= i_cfg_wdata;
            end
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (i_m_tready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_act   <= i_s_tuser;
                        r_kb    <= $signed(i_s_tdata[KEY_BITS-1:0]);
                        r_ke    <= $signed(i_s_tdata[2*KEY_BITS-1:KEY_BITS]);
                        r_val   <= i_s_tdata[EW+KEY_BITS-1:2*KEY_BITS];
                        r_idx   <= '0;
                        r_res   <= r_default;
                        r_endv  <= r_default;
                        r_prev  <= r_default;
                        r_m     <= '0;
                        r_ovf   <= 1'b0;
                        r_phase <= PH_BEGIN;
                        r_stat  <= STAT_DONE;
                        if (i_s_tuser == ACT_ASSIGN &&
                            !($signed(i_s_tdata[KEY_BITS-1:0]) <
                              $signed(i_s_tdata[2*KEY_BITS-1:KEY_BITS]))) begin
                            r_stat  <= STAT_EMPTY;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (r_act == ACT_LOOKUP) begin
                        if (at_end) begin
                            r_state <= S_DONE;
                        end else begin
                            if (cur_key <= r_kb) begin
                                r_res <= cur_val;
                            end
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (r_phase == PH_TAIL && at_end) begin
                        // Commit the rebuilt table unless it overflowed
                        if (r_ovf) begin
                            r_stat <= STAT_FULL;
                        end else begin
                            r_bank  <= !r_bank;
                            r_count <= r_m;
                        end
                        r_state <= S_DONE;
                    end else begin
                        if (e_new) begin
                            if (r_m == CW'(MAX_BOUNDS)) begin
                                r_ovf <= 1'b1;
                            end else if (!r_ovf) begin
                                r_m <= r_m + 1'b1;
                            end
                        end
                        if (e_do) begin
                            r_prev <= e_v;
                        end
                        if (!at_end && cur_key <= r_ke && e_adv) begin
                            r_endv <= cur_val;
                        end
                        r_phase <= e_phase;
                        if (e_adv) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    // Hand over the result once the output register is free
                    if (out_load) begin
                        r_odata <= OUT_W'({r_stat,
                                           (r_act == ACT_LOOKUP) ? r_res
                                                                 : {VALUE_BITS{1'b0}}});
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> bench/interval_range_map_top_tb.sv
// Self-checking bench for interval_range_map_top: drives lookup and assign words,
// predicts each result with a local copy of the boundary table and checks it.
// Depends on irm_pkg and the RTL of interval_range_map_top.
`timescale 1ns / 1ps

module interval_range_map_top_tb;
    import irm_pkg::*;

    localparam int NB       = DEF_MAX_BOUNDS;
    localparam int KB       = DEF_KEY_BITS;
    localparam int VB       = DEF_VALUE_BITS;
    localparam int SDW      = ((2*KB+VB+7)/8)*8;
    localparam int MDW      = ((VB+STATUS_W+7)/8)*8;
    localparam int SETTLE   = 2*NB + 20;
    localparam int LIMIT    = 3000000;
    localparam int PHASES   = 8;
    localparam int PER_PHASE = 125;

    typedef logic signed [KB-1:0] key_t;
    typedef logic [VB-1:0]        val_t;
    // status above read_value, as on the output word
    typedef struct packed {
        t_status st;
        val_t    rv;
    } result_t;
    typedef struct {
        logic    act;
        key_t    kb;
        key_t    ke;
        val_t    v;
        bit      typed;
        result_t res;
    } row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wen;
    logic [VB-1:0]    i_cfg_wdata;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [SDW-1:0]   i_s_tdata;   // key_begin, key_end, new_value
    logic             i_s_tuser;   // action
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [MDW-1:0]   o_m_tdata;   // read_value, status

    interval_range_map_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Local copy of the map
    key_t    map_keys[NB];
    val_t    map_vals[NB];
    int      map_count;
    val_t    map_default;
    result_t pending_results[$];

    int  n_errors, n_lookups, n_assigns, n_full, n_empty, n_checked;
    int  cycle_count;
    bit  hold_req;
    bit  quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung block
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic val_t value_at(key_t k);
        val_t r;
        r = map_default;
        for (int i = 0; i < map_count; i++) begin
            if (map_keys[i] <= k) r = map_vals[i];
            else break;
        end
        return r;
    endfunction

    // Paint v over [kb, ke) and rebuild the table in canonical form
    function automatic t_status paint_range(key_t kb, key_t ke, val_t v);
        key_t tk[NB+2];
        val_t tv[NB+2];
        val_t end_v, prev;
        int   n, m;
        n = 0;
        m = 0;
        if (kb >= ke) return STAT_EMPTY;
        end_v = value_at(ke);
        for (int i = 0; i < map_count; i++) begin
            if (map_keys[i] < kb) begin
                tk[n] = map_keys[i];
                tv[n] = map_vals[i];
                n++;
            end
        end
        tk[n] = kb; tv[n] = v;     n++;
        tk[n] = ke; tv[n] = end_v; n++;
        for (int i = 0; i < map_count; i++) begin
            if (map_keys[i] > ke && n < NB+2) begin
                tk[n] = map_keys[i];
                tv[n] = map_vals[i];
                n++;
            end
        end
        // Drop boundaries that repeat the value before them
        prev = map_default;
        for (int i = 0; i < n; i++) begin
            if (tv[i] != prev) begin
                tk[m] = tk[i];
                tv[m] = tv[i];
                prev  = tv[i];
                m++;
            end
        end
        if (m > NB) return STAT_FULL;
        for (int i = 0; i < m; i++) begin
            map_keys[i] = tk[i];
            map_vals[i] = tv[i];
        end
        map_count = m;
        return STAT_DONE;
    endfunction

    // Offer one word and wait for it to be taken; leaves tvalid high
    task automatic send_word(logic act, key_t kb, key_t ke, val_t v, bit typed, result_t tres);
        result_t r;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {{(SDW-2*KB-VB){1'b0}}, v, ke, kb};
        do @(posedge i_clk); while (!o_s_tready);
        if (act == ACT_LOOKUP) begin
            r.rv = value_at(kb);
            r.st = STAT_DONE;
            n_lookups++;
        end else begin
            r.rv = '0;
            r.st = paint_range(kb, ke, v);
            n_assigns++;
            if (r.st == STAT_FULL)  n_full++;
            if (r.st == STAT_EMPTY) n_empty++;
        end
        pending_results.push_back(typed ? tres : r);
    endtask

    // Idle gap after a word: mostly none, some short, a few long
    task automatic sender_gap();
        int g, p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55) g = 0;
        else if (p < 92)     g = $urandom_range(1, 3);
        else                 g = $urandom_range(8, 40);
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is back, then let the block settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_default(val_t v);
        drain();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        map_default = v;
    endtask

    function automatic key_t pick_key();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0, 1, 2, 3, 4, 5: return key_t'(int'($urandom_range(0, 80)) - 40);
            6:                return key_t'($urandom);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b1, {(KB-1){1'b0}}};
                    1:       return {1'b0, {(KB-1){1'b1}}};
                    2:       return {1'b1, {(KB-2){1'b0}}, 1'b1};
                    default: return {1'b0, {(KB-2){1'b1}}, 1'b0};
                endcase
            end
            default:          return key_t'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic val_t pick_value();
        case ($urandom_range(0, 7))
            0:       return map_default;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            default: return val_t'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic act;
        key_t kb, ke;
        act = ($urandom_range(0, 1) == 1) ? ACT_ASSIGN : ACT_LOOKUP;
        kb  = pick_key();
        ke  = pick_key();
        // keep most assigns well ordered so the table actually fills
        if (act == ACT_ASSIGN && kb > ke && $urandom_range(0, 9) < 8) begin
            key_t t;
            t  = kb;
            kb = ke;
            ke = t;
        end
        if (act == ACT_ASSIGN && kb == ke && $urandom_range(0, 3) != 0) ke = kb + 1;
        send_word(act, kb, ke, pick_value(), 1'b0, '0);
        sender_gap();
    endtask

    // Receive side: random back-pressure and result check
    int stall_left, hold_left;
    always @(posedge i_clk) begin
        result_t got, want;
        int p;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = result_t'(o_m_tdata[VB+STATUS_W-1:0]);
            n_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word rv=%02h st=%0d", $time, got.rv, got.st);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.rv !== want.rv) begin
                    $display("%0t: read_value expected %02h actual %02h", $time, want.rv, got.rv);
                    n_errors++;
                end
                if (got.st !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                    n_errors++;
                end
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (quiet || p < 70) stall_left = 0;
            else if (p < 95)     stall_left = $urandom_range(1, 3);
            else                 stall_left = $urandom_range(10, 50);
            i_m_tready <= (stall_left == 0);
        end
    end

    // Directed rows; typed results only where obvious
    localparam key_t KMIN = {1'b1, {(KB-1){1'b0}}};
    localparam key_t KMAX = {1'b0, {(KB-1){1'b1}}};
    row_t rows[$];

    function automatic row_t mk(logic a, key_t kb, key_t ke, val_t v, bit typed,
                                val_t rv, t_status st);
        row_t r;
        r.act = a; r.kb = kb; r.ke = ke; r.v = v; r.typed = typed;
        r.res.rv = rv; r.res.st = st;
        return r;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = ACT_LOOKUP;
        i_m_tready  = 1'b0;
        map_count   = 0;
        map_default = '0;
        cycle_count = 0;
        hold_req    = 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        hold_left   = 0;

        rows.push_back(mk(ACT_LOOKUP, 0, 0, 0, 1, 8'h00, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, KMIN, 0, 0, 1, 8'h00, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, KMAX, 0, 0, 1, 8'h00, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, 5, 5, 8'h11, 1, 8'h00, STAT_EMPTY));
        rows.push_back(mk(ACT_ASSIGN, 10, -3, 8'h11, 1, 8'h00, STAT_EMPTY));
        rows.push_back(mk(ACT_ASSIGN, KMAX, KMIN, 8'hff, 1, 8'h00, STAT_EMPTY));
        rows.push_back(mk(ACT_ASSIGN, KMIN, KMAX, 8'hff, 1, 8'h00, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, KMIN, 0, 0, 1, 8'hff, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, KMAX, 0, 0, 1, 8'h00, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, -100, 100, 8'h00, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, 0, 0, 0, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, -101, 0, 0, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, -50, 50, 8'hff, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, 100, 0, 0, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, KMIN, KMIN + 1, 8'h55, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, KMAX - 1, KMAX, 8'haa, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, KMAX - 1, 0, 0, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_ASSIGN, KMIN, KMAX, 8'h00, 0, 0, STAT_DONE));
        rows.push_back(mk(ACT_LOOKUP, 0, 0, 0, 1, 8'h00, STAT_DONE));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, empty ranges, merges
        set_default(8'h00);
        foreach (rows[i]) begin
            send_word(rows[i].act, rows[i].kb, rows[i].ke, rows[i].v, rows[i].typed, rows[i].res);
            sender_gap();
        end

        // Fill the table with disjoint islands until an assign is refused
        for (int i = 0; i < 17; i++) begin
            send_word(ACT_ASSIGN, 20*i, 20*i + 5, val_t'(i + 1), 0, '0);
            sender_gap();
        end
        send_word(ACT_LOOKUP, 0, 0, 0, 0, '0);

        // Default now equals the first boundary; lookups still see it
        set_default(8'h01);
        send_word(ACT_LOOKUP, 2, 0, 0, 0, '0);
        send_word(ACT_LOOKUP, -7, 0, 0, 0, '0);
        send_word(ACT_ASSIGN, 1000, 1001, 8'h07, 0, '0);
        send_word(ACT_LOOKUP, 21, 0, 0, 0, '0);

        // Random phases, each with its own default value
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_default(8'hff);
                1:       set_default(8'h00);
                3:       set_default(8'h80);
                default: set_default(val_t'($urandom));
            endcase
            quiet = (ph == 5);
            for (int k = 0; k < PER_PHASE; k++) begin
                // long receiver hold while words keep arriving back to back
                if (ph == 2 && k == 10) begin
                    hold_req = 1'b1;
                    for (int j = 0; j < 20; j++)
                        send_word(ACT_LOOKUP, pick_key(), 0, 0, 0, '0);
                end
                // occasional wipe back to the default over the whole key space
                if ($urandom_range(0, 99) == 0) begin
                    send_word(ACT_ASSIGN, KMIN, KMAX, map_default, 0, '0);
                    sender_gap();
                end
                send_random();
            end
        end

        drain();
        $display("Covered %0d lookups and %0d assigns (%0d empty, %0d refused as full),",
                 n_lookups, n_assigns, n_empty, n_full);
        $display("%0d result words checked over %0d cycles.", n_checked, cycle_count);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
